FILE: design/cubic_bezier_point_eval_top_assert.svh
// ---------------------------------------------------------------------------
// cubic bezier point evaluator assertion macros
// clocked on clk, disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_POINT_EVAL_TOP_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVAL_TOP_ASSERT_SVH

// same-cycle implication
`define CBEZ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbez check failed");

// next-cycle implication
`define CBEZ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbez check failed");

`endif

FILE: design/cbez_pkg.sv
// ---------------------------------------------------------------------------
// cbez_pkg
// shared constants of the cubic bezier point evaluator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbez_pkg;

  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned U_FRAC_BITS_DEF = 16;

  localparam int unsigned NUM_REGS     = 8;
  localparam int unsigned CFG_IDX_BITS = $clog2(NUM_REGS);

  // register map
  localparam logic [CFG_IDX_BITS-1:0] REG_P0_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_P0_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_P1_X = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_P1_Y = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_P2_X = CFG_IDX_BITS'(4);
  localparam logic [CFG_IDX_BITS-1:0] REG_P2_Y = CFG_IDX_BITS'(5);
  localparam logic [CFG_IDX_BITS-1:0] REG_P3_X = CFG_IDX_BITS'(6);
  localparam logic [CFG_IDX_BITS-1:0] REG_P3_Y = CFG_IDX_BITS'(7);

  // pipeline register stages from input to output
  localparam int unsigned NUM_STAGES = 6;

endpackage

`default_nettype wire

FILE: design/cbez_param_if.sv
// ---------------------------------------------------------------------------
// cbez_param_if
// valid/ready channel carrying the curve parameter u
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cbez_param_if #(
  parameter int unsigned U_FRAC_BITS = cbez_pkg::U_FRAC_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [U_FRAC_BITS-1:0] param_u;

  modport source (output valid, output param_u, input ready);
  modport sink   (input valid, input param_u, output ready);
endinterface

`default_nettype wire

FILE: design/cbez_point_if.sv
// ---------------------------------------------------------------------------
// cbez_point_if
// valid/ready channel carrying one evaluated curve point
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cbez_point_if #(
  parameter int unsigned COORD_BITS = cbez_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

FILE: design/cubic_bezier_point_eval_top.sv
// ---------------------------------------------------------------------------
// cubic_bezier_point_eval_top
// evaluates a cubic bezier curve at one parameter u per beat, truncated
// toward zero to integer pixel coordinates
// ---------------------------------------------------------------------------
//
// channel    dir  handshake             payload
// ---------  ---  --------------------  -------------------------------------
// param_ch   in   valid / ready         param_u   u = value / 2^U_FRAC_BITS
// point_ch   out  valid / ready         point_x, point_y (signed pixels)
// cfg        in   cfg_wr_en, no wait    cfg_index, cfg_data (control points)
//
// one beat per clock sustained while point_ch.ready is high
// the pipeline has six register stages: u and 1-u, squares,
// cubes (weights), weight times coordinate, four-term sum, truncation
// reset (rst, synchronous) empties the pipeline and zeroes all control points
// a stall backs up only as far as the first empty stage, so bubbles close up
// and input is taken whenever any stage ahead has room
//
`timescale 1ns / 1ps
`default_nettype none

`include "cubic_bezier_point_eval_top_assert.svh"

module cubic_bezier_point_eval_top #(
  parameter int unsigned COORD_BITS  = cbez_pkg::COORD_BITS_DEF,
  parameter int unsigned U_FRAC_BITS = cbez_pkg::U_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  cbez_param_if.sink                             param_ch,
  cbez_point_if.source                           point_ch,
  input  wire logic                              cfg_wr_en,
  input  wire logic [cbez_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [COORD_BITS-1:0]             cfg_data
);
  import cbez_pkg::*;

  // widths
  localparam int unsigned F         = U_FRAC_BITS;
  localparam int unsigned C         = COORD_BITS;
  localparam int unsigned CW        = C + 2;          // coordinate, possibly tripled
  localparam int unsigned SQ_BITS   = 2 * F + 1;      // v^2 reaches 2^(2F)
  localparam int unsigned W_BITS    = 3 * F + 1;      // v^3 reaches 2^(3F)
  localparam int unsigned PROD_BITS = CW + W_BITS + 1;
  localparam int unsigned SUM_BITS  = PROD_BITS + 2;
  localparam int unsigned SCALE_SH  = 3 * F;

  // -------------------------------------------------------------------------
  // control points; the middle two are kept pre-multiplied by three, which
  // folds the binomial factor of the inner bernstein weights into them
  // -------------------------------------------------------------------------
  logic signed [CW-1:0] coef_x [4];
  logic signed [CW-1:0] coef_y [4];
  logic signed [CW-1:0] cfg_one;
  logic signed [CW-1:0] cfg_three;

  assign cfg_one   = CW'($signed(cfg_data));
  assign cfg_three = cfg_one + (cfg_one <<< 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        coef_x[i] <= '0;
        coef_y[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_P0_X: coef_x[0] <= cfg_one;
        REG_P0_Y: coef_y[0] <= cfg_one;
        REG_P1_X: coef_x[1] <= cfg_three;
        REG_P1_Y: coef_y[1] <= cfg_three;
        REG_P2_X: coef_x[2] <= cfg_three;
        REG_P2_Y: coef_y[2] <= cfg_three;
        REG_P3_X: coef_x[3] <= cfg_one;
        REG_P3_Y: coef_y[3] <= cfg_one;
        default: begin
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // pipeline flow control: a stage loads when it is empty or its
  // successor loads in the same cycle
  // -------------------------------------------------------------------------
  logic vld [NUM_STAGES];
  logic rdy [NUM_STAGES];

  always_comb begin
    rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || point_ch.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        vld[0] <= param_ch.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign param_ch.ready = rdy[0];

  // stage 0: t and v = 1 - u
  logic [F-1:0] s0_t;
  logic [F:0]   s0_v;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_t <= param_ch.param_u;
      s0_v <= ((F+1)'(1) << F) - (F+1)'(param_ch.param_u);
    end
  end

  // stage 1: second powers
  logic [F-1:0]       s1_t;
  logic [F:0]         s1_v;
  logic [2*F-1:0]     s1_tt;
  logic [2*F-1:0]     s1_tv;
  logic [SQ_BITS-1:0] s1_vv;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_t  <= s0_t;
      s1_v  <= s0_v;
      s1_tt <= s0_t * s0_t;
      // t * v stays below 2^(2F)
      s1_tv <= (2*F)'(s0_t) * (2*F)'(s0_v);
      s1_vv <= s0_v * s0_v;
    end
  end

  // stage 2: bernstein weights without the factor three
  logic [W_BITS-1:0] s2_w [4];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_w[0] <= s1_vv * s1_v;
      s2_w[1] <= s1_tv * s1_v;
      s2_w[2] <= s1_tv * s1_t;
      s2_w[3] <= s1_tt * s1_t;
    end
  end

  // stage 3: weight times coordinate, one lane per control point and axis
  logic signed [PROD_BITS-1:0] s3_px [4];
  logic signed [PROD_BITS-1:0] s3_py [4];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 4; i++) begin
        s3_px[i] <= coef_x[i] * $signed({1'b0, s2_w[i]});
        s3_py[i] <= coef_y[i] * $signed({1'b0, s2_w[i]});
      end
    end
  end

  // stage 4: exact weighted sums, scaled by 2^(3F)
  logic signed [SUM_BITS-1:0] s4_sx;
  logic signed [SUM_BITS-1:0] s4_sy;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_sx <= SUM_BITS'(s3_px[0]) + SUM_BITS'(s3_px[1])
             + SUM_BITS'(s3_px[2]) + SUM_BITS'(s3_px[3]);
      s4_sy <= SUM_BITS'(s3_py[0]) + SUM_BITS'(s3_py[1])
             + SUM_BITS'(s3_py[2]) + SUM_BITS'(s3_py[3]);
    end
  end

  // stage 5: drop the scale; a negative sum with a nonzero fraction rounds
  // up by one so the result truncates toward zero
  logic x_up;
  logic y_up;

  assign x_up = s4_sx[SUM_BITS-1] && (|s4_sx[SCALE_SH-1:0]);
  assign y_up = s4_sy[SUM_BITS-1] && (|s4_sy[SCALE_SH-1:0]);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      point_ch.point_x <= $signed(s4_sx[SCALE_SH +: C] + C'(x_up));
      point_ch.point_y <= $signed(s4_sy[SCALE_SH +: C] + C'(y_up));
    end
  end

  assign point_ch.valid = vld[NUM_STAGES-1];

  // -------------------------------------------------------------------------
  // checks
  // -------------------------------------------------------------------------
  logic [W_BITS+1:0] s2_wsum;

  assign s2_wsum = (W_BITS+2)'(s2_w[0]) + (W_BITS+2)'(s2_w[3])
                 + (W_BITS+2)'(3) * ((W_BITS+2)'(s2_w[1]) + (W_BITS+2)'(s2_w[2]));

  // the four weights of a curve point always add up to one
  `CBEZ_ASSERT_IMP(a_weight_sum, vld[2], s2_wsum == ((W_BITS+2)'(1) << SCALE_SH))
  // a held stage keeps its beat and its weights
  `CBEZ_ASSERT_NXT(a_stage_hold, vld[2] && !rdy[2], vld[2] && $stable(s2_wsum))
  // a beat leaving the sum stage reaches the output register
  `CBEZ_ASSERT_NXT(a_sum_to_out, vld[4] && rdy[4], vld[5])

endmodule

`default_nettype wire
